/* sv/mcmp_pkg.sv */
// Shared types and constants for the MIDI channel message parser.
`default_nettype none

package mcmp_pkg;

    // Result kinds as they appear on the result channel.
    typedef enum logic [2:0] {
        KIND_NOTE_OFF    = 3'd0,
        KIND_NOTE_ON     = 3'd1,
        KIND_CONTROL     = 3'd2,
        KIND_BEND        = 3'd3,
        KIND_ERROR       = 3'd4,
        KIND_UNSUPPORTED = 3'd5
    } kind_t;

    // Parser phase: waiting for a status byte or for one of the two data bytes.
    typedef enum logic [1:0] {
        PH_STATUS = 2'd0,
        PH_DATA1  = 2'd1,
        PH_DATA2  = 2'd2
    } phase_t;

    // Command field (status bits 6..4) of the supported messages.
    localparam logic [2:0] CMD_NOTE_OFF = 3'd0;
    localparam logic [2:0] CMD_NOTE_ON  = 3'd1;
    localparam logic [2:0] CMD_CONTROL  = 3'd3;
    localparam logic [2:0] CMD_BEND     = 3'd6;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CHAN_W  = 4;
    localparam int unsigned VALUE_W = 7;
    localparam int unsigned BEND_W  = 14;

    // One result item as it moves from the parser to the output stage.
    typedef struct packed {
        kind_t                kind;
        logic [CHAN_W-1:0]    channel;
        logic [VALUE_W-1:0]   first_value;
        logic [VALUE_W-1:0]   second_value;
        logic [BEND_W-1:0]    bend_value;
    } result_t;

endpackage

`default_nettype wire

/* sv/midi_channel_message_parser.sv */
// Top level of the MIDI channel message parser.
// Takes one raw MIDI byte per transaction and gives at most one result per byte: a note off,
// note on, control change or pitch bend message after its status byte and two data bytes,
// an erroneous-byte result for a stray byte with bit 7 clear, or an unsupported result for
// any other status byte; zero bytes between messages are dropped. Data bytes are masked to
// seven bits whatever their top bit, and running status is not handled. A byte may be sent
// in every cycle while s_axis_tready is high: it is parsed while it sits in the input
// register, and its result then moves into the output register, or into the skid entry
// while m_axis_tready holds the output back. A skid entry behind the output register keeps
// s_axis_tready free of any combinational path from m_axis_tready.
`default_nettype none

module midi_channel_message_parser
    import mcmp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // in_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // channel, first_value, second_value, bend_value
    output logic [2:0]       m_axis_tuser    // event_kind
);

    logic    res_valid;
    logic    res_ready;
    result_t res_data;
    result_t out_data;

    mcmp_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_byte   (s_axis_tdata),
        .res_ready (res_ready),
        .res_valid (res_valid),
        .res_data  (res_data)
    );

    mcmp_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_ready  (res_ready),
        .in_data   (res_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_data)
    );

    // Pack the result fields onto the stream, lowest field first.
    assign m_axis_tuser = out_data.kind;
    assign m_axis_tdata = {out_data.bend_value, out_data.second_value,
                           out_data.first_value, out_data.channel};

endmodule

`default_nettype wire

/* sv/mcmp_parser.sv */
// Input byte register and message parsing state machine.
`default_nettype none

module mcmp_parser
    import mcmp_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [BYTE_W-1:0] in_byte,
    input  wire logic              res_ready,
    output logic                   res_valid,
    output result_t                res_data
);

    logic              byte_valid_reg;
    logic [BYTE_W-1:0] byte_reg;
    phase_t            phase_reg, phase_next;
    logic [1:0]        pend_kind_reg, pend_kind_next;
    logic [CHAN_W-1:0] pend_chan_reg, pend_chan_next;
    logic [VALUE_W-1:0] held_reg, held_next;
    logic              proc;
    logic [2:0]        cmd;
    logic              cmd_supported;
    logic [1:0]        cmd_kind;

    // A held byte is worked on once the output stage has room for a result.
    assign proc     = byte_valid_reg && res_ready;
    assign in_ready = !byte_valid_reg || res_ready;
    assign cmd      = byte_reg[6:4];

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_valid_reg <= 1'b0;
        end else if (in_ready) begin
            byte_valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            byte_reg <= in_byte;
        end
    end

    // Map the command field of a status byte to a message kind.
    always_comb begin
        cmd_supported = 1'b1;
        cmd_kind      = KIND_NOTE_OFF[1:0];
        case (cmd)
            CMD_NOTE_OFF: cmd_kind = KIND_NOTE_OFF[1:0];
            CMD_NOTE_ON:  cmd_kind = KIND_NOTE_ON[1:0];
            CMD_CONTROL:  cmd_kind = KIND_CONTROL[1:0];
            CMD_BEND:     cmd_kind = KIND_BEND[1:0];
            default:      cmd_supported = 1'b0;
        endcase
    end

    // Next state.
    always_comb begin
        phase_next     = phase_reg;
        pend_kind_next = pend_kind_reg;
        pend_chan_next = pend_chan_reg;
        held_next      = held_reg;
        if (proc) begin
            case (phase_reg)
                PH_DATA1: begin
                    held_next  = byte_reg[VALUE_W-1:0];
                    phase_next = PH_DATA2;
                end
                PH_DATA2: begin
                    phase_next = PH_STATUS;
                end
                default: begin
                    phase_next = PH_STATUS;
                    if (byte_reg[7] && cmd_supported) begin
                        pend_kind_next = cmd_kind;
                        pend_chan_next = byte_reg[CHAN_W-1:0];
                        phase_next     = PH_DATA1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_STATUS;
            pend_kind_reg <= '0;
            pend_chan_reg <= '0;
            held_reg      <= '0;
        end else begin
            phase_reg     <= phase_next;
            pend_kind_reg <= pend_kind_next;
            pend_chan_reg <= pend_chan_next;
            held_reg      <= held_next;
        end
    end

    // Result outputs.
    always_comb begin
        res_valid = 1'b0;
        res_data  = '0;
        case (phase_reg)
            PH_DATA1: begin
                res_valid = 1'b0;
            end
            PH_DATA2: begin
                res_valid        = proc;
                res_data.kind    = kind_t'({1'b0, pend_kind_reg});
                res_data.channel = pend_chan_reg;
                if (pend_kind_reg == KIND_BEND[1:0]) begin
                    res_data.bend_value = {byte_reg[VALUE_W-1:0], held_reg};
                end else begin
                    res_data.first_value  = held_reg;
                    res_data.second_value = byte_reg[VALUE_W-1:0];
                end
            end
            default: begin
                if (byte_reg == '0) begin
                    res_valid = 1'b0;
                end else if (!byte_reg[7]) begin
                    res_valid     = proc;
                    res_data.kind = KIND_ERROR;
                end else if (!cmd_supported) begin
                    res_valid     = proc;
                    res_data.kind = KIND_UNSUPPORTED;
                end
            end
        endcase
    end

    // A result only comes out of a byte that is being worked on.
    assert property (@(posedge aclk) disable iff (!aresetn) res_valid |-> proc)
        else $error("parser result without a processed byte");

    // The second data byte always closes the message.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (proc && phase_reg == PH_DATA2) |=> phase_reg == PH_STATUS)
        else $error("message not closed after second data byte");

    // Error kinds carry no channel.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && (res_data.kind == KIND_ERROR || res_data.kind == KIND_UNSUPPORTED))
        |-> res_data.channel == '0)
        else $error("error result with a nonzero channel");

endmodule

`default_nettype wire

/* sv/mcmp_skid.sv */
// Output register with a skid stage for the result channel.
`default_nettype none

module mcmp_skid
    import mcmp_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire result_t in_data,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      out_data
);

    logic    out_valid_reg;
    result_t out_data_reg;
    logic    skid_valid_reg;
    result_t skid_data_reg;

    // Ready depends on registered state only, so the two sides stay apart.
    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Move the skid entry or the new result forward when the output is free.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_ready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= in_valid;
            end
        end else if (in_valid && !skid_valid_reg) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (out_ready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_data_reg <= skid_data_reg;
            end else if (in_valid) begin
                out_data_reg <= in_data;
            end
        end else if (in_valid && !skid_valid_reg) begin
            skid_data_reg <= in_data;
        end
    end

    // The skid entry is only filled behind a stalled output.
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with an empty output register");

    // No result is offered while the skid entry is occupied.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid |-> !skid_valid_reg)
        else $error("result offered to a full output stage");

    // A filled skid entry drains into the output when the consumer takes one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && out_ready) |=> (out_valid_reg && !skid_valid_reg))
        else $error("skid entry not drained");

endmodule

`default_nettype wire
